/* hw/rtl/krt_pkg.sv */
// Package for the keyed record table: capacity, field widths, opcodes,
// status codes and the sequencer state type. No dependencies.
`default_nettype none

package krt_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    localparam int OP_W    = 3;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 3;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;

    localparam int IN_TDATA_W  = 2 * DATA_W;
    localparam int OUT_FLD_W   = 2 * DATA_W + POS_W + COUNT_W;
    localparam int OUT_TDATA_W = ((OUT_FLD_W + 7) / 8) * 8;

    localparam int POS_LSB   = 2 * DATA_W;
    localparam int COUNT_LSB = 2 * DATA_W + POS_W;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd1;
    localparam logic [OP_W-1:0] OP_UPDATE = 3'd2;
    localparam logic [OP_W-1:0] OP_ERASE  = 3'd3;
    localparam logic [OP_W-1:0] OP_LIST   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_COMPARE,
        S_MISS,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_EMIT,
        S_LIST_RD,
        S_LIST_OUT
    } seq_state_t;

    typedef struct packed {
        logic              wr_key_en;
        logic              wr_val_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [DATA_W-1:0] wr_key;
        logic [DATA_W-1:0] wr_val;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
    } store_req_t;

endpackage

`default_nettype wire

/* hw/rtl/krt_store.sv */
// Key and value record store: one write port, one registered read port.
// Depends on krt_pkg.
`default_nettype none

module krt_store (
    input  wire logic                      clk,
    input  wire krt_pkg::store_req_t       req,
    output logic [krt_pkg::DATA_W-1:0]     rd_key,
    output logic [krt_pkg::DATA_W-1:0]     rd_val
);
    import krt_pkg::*;

    logic [DATA_W-1:0] key_mem [DEPTH];
    logic [DATA_W-1:0] val_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_key_en)
        begin
            key_mem[req.wr_addr] <= req.wr_key;
        end
        if (req.wr_val_en)
        begin
            val_mem[req.wr_addr] <= req.wr_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_key <= key_mem[req.rd_addr];
            rd_val <= val_mem[req.rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/keyed_record_table_unit.sv */
// Keyed record table: insertion-ordered key/value records scanned by one comparator.
// Depends on krt_pkg and krt_store.
// Each record compared is read, then compared; a hit goes to the result, a miss or
// insert passes a miss step; erase moves each later record down. List returns each
// record; empty list: one result. Next request taken once the result is loaded.
// Reset: table empty, no result pending. Record storage is not cleared.
`default_nettype none

module keyed_record_table_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] key, [63:32] value
    input  wire logic [krt_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // [2:0] opcode
    input  wire logic [krt_pkg::OP_W-1:0]       s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [31:0] found_key, [63:32] found_value, [67:64] position,
    // [72:68] record_count, rest zero
    output logic [krt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // [2:0] status
    output logic [krt_pkg::STAT_W-1:0]          m_axis_tuser,
    output logic                                m_axis_tlast
);
    import krt_pkg::*;

    seq_state_t          state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [DATA_W-1:0]   key_reg, key_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    occ_reg, occ_next;

    logic [STAT_W-1:0]   res_status_reg, res_status_next;
    logic [DATA_W-1:0]   res_key_reg, res_key_next;
    logic [DATA_W-1:0]   res_val_reg, res_val_next;
    logic [POS_W-1:0]    res_pos_reg, res_pos_next;
    logic [COUNT_W-1:0]  res_count_reg, res_count_next;

    logic                m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]   m_status_reg, m_status_next;
    logic [DATA_W-1:0]   m_key_reg, m_key_next;
    logic [DATA_W-1:0]   m_val_reg, m_val_next;
    logic [POS_W-1:0]    m_pos_reg, m_pos_next;
    logic [COUNT_W-1:0]  m_count_reg, m_count_next;
    logic                m_last_reg, m_last_next;

    store_req_t          store_req;
    logic [DATA_W-1:0]   rd_key;
    logic [DATA_W-1:0]   rd_val;

    logic                in_fire;
    logic                out_free;
    logic                hit;
    logic                at_end;
    logic [CNT_W-1:0]    idx_inc;
    logic [OP_W-1:0]     in_op;

    krt_store u_store (
        .clk    (clk),
        .req    (store_req),
        .rd_key (rd_key),
        .rd_val (rd_val)
    );

    assign in_op    = s_axis_tuser;
    assign in_fire  = s_axis_tvalid && (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_axis_tready;
    assign idx_inc  = idx_reg + 1'b1;
    assign hit      = (rd_key == key_reg);
    assign at_end   = (idx_inc == occ_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_op == OP_LIST)
                    begin
                        state_next = (occ_reg == '0) ? S_EMIT : S_LIST_RD;
                    end
                    else if (in_op < OP_LIST)
                    begin
                        state_next = (occ_reg == '0) ? S_MISS : S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_COMPARE;
            end
            S_COMPARE:
            begin
                if (hit)
                begin
                    state_next = (op_reg == OP_ERASE) ? S_SHIFT_RD : S_EMIT;
                end
                else
                begin
                    state_next = at_end ? S_MISS : S_READ;
                end
            end
            S_MISS:
            begin
                state_next = S_EMIT;
            end
            S_SHIFT_RD:
            begin
                state_next = (idx_inc < occ_reg) ? S_SHIFT_WR : S_EMIT;
            end
            S_SHIFT_WR:
            begin
                state_next = S_SHIFT_RD;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_LIST_RD:
            begin
                state_next = S_LIST_OUT;
            end
            S_LIST_OUT:
            begin
                if (out_free)
                begin
                    state_next = at_end ? S_IDLE : S_LIST_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and store control
    always_comb
    begin
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        idx_next        = idx_reg;
        occ_next        = occ_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_val_next    = res_val_reg;
        res_pos_next    = res_pos_reg;
        res_count_next  = res_count_reg;
        m_status_next   = m_status_reg;
        m_key_next      = m_key_reg;
        m_val_next      = m_val_reg;
        m_pos_next      = m_pos_reg;
        m_count_next    = m_count_reg;
        m_last_next     = m_last_reg;
        m_valid_next    = m_axis_tready ? 1'b0 : m_valid_reg;

        store_req           = '0;
        store_req.wr_key    = key_reg;
        store_req.wr_val    = val_reg;
        store_req.wr_addr   = idx_reg[IDX_W-1:0];
        store_req.rd_addr   = idx_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next         = in_op;
                    key_next        = s_axis_tdata[DATA_W-1:0];
                    val_next        = s_axis_tdata[2*DATA_W-1:DATA_W];
                    idx_next        = '0;
                    res_status_next = ST_EMPTY;
                    res_key_next    = '0;
                    res_val_next    = '0;
                    res_pos_next    = '0;
                    res_count_next  = '0;
                end
            end
            S_READ, S_LIST_RD:
            begin
                store_req.rd_en = 1'b1;
            end
            S_COMPARE:
            begin
                res_key_next   = rd_key;
                res_val_next   = rd_val;
                res_pos_next   = POS_W'(idx_reg);
                res_count_next = COUNT_W'(occ_reg);
                if (hit)
                begin
                    case (op_reg)
                        OP_INSERT:
                        begin
                            res_status_next = ST_DUPLICATE;
                        end
                        OP_UPDATE:
                        begin
                            res_status_next     = ST_OK;
                            res_val_next        = val_reg;
                            store_req.wr_val_en = 1'b1;
                        end
                        OP_ERASE:
                        begin
                            res_status_next = ST_OK;
                            res_count_next  = COUNT_W'(occ_reg - 1'b1);
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                        end
                    endcase
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            S_MISS:
            begin
                res_pos_next   = '0;
                res_key_next   = '0;
                res_val_next   = '0;
                res_count_next = COUNT_W'(occ_reg);
                if (op_reg != OP_INSERT)
                begin
                    res_status_next = ST_NOT_FOUND;
                end
                else if (occ_reg >= CNT_W'(DEPTH))
                begin
                    res_status_next = ST_FULL;
                end
                else
                begin
                    res_status_next     = ST_OK;
                    res_key_next        = key_reg;
                    res_val_next        = val_reg;
                    res_pos_next        = POS_W'(occ_reg);
                    res_count_next      = COUNT_W'(occ_reg + 1'b1);
                    occ_next            = occ_reg + 1'b1;
                    store_req.wr_addr   = occ_reg[IDX_W-1:0];
                    store_req.wr_key_en = 1'b1;
                    store_req.wr_val_en = 1'b1;
                end
            end
            S_SHIFT_RD:
            begin
                if (idx_inc < occ_reg)
                begin
                    store_req.rd_en   = 1'b1;
                    store_req.rd_addr = idx_inc[IDX_W-1:0];
                end
                else
                begin
                    occ_next = occ_reg - 1'b1;
                end
            end
            S_SHIFT_WR:
            begin
                store_req.wr_key    = rd_key;
                store_req.wr_val    = rd_val;
                store_req.wr_key_en = 1'b1;
                store_req.wr_val_en = 1'b1;
                idx_next            = idx_inc;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_key_next    = res_key_reg;
                    m_val_next    = res_val_reg;
                    m_pos_next    = res_pos_reg;
                    m_count_next  = res_count_reg;
                    m_last_next   = 1'b1;
                end
            end
            S_LIST_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = ST_OK;
                    m_key_next    = rd_key;
                    m_val_next    = rd_val;
                    m_pos_next    = POS_W'(idx_reg);
                    m_count_next  = COUNT_W'(occ_reg);
                    m_last_next   = at_end;
                    idx_next      = idx_inc;
                end
            end
            default:
            begin
                store_req.rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_val_reg    <= res_val_next;
        res_pos_reg    <= res_pos_next;
        res_count_reg  <= res_count_next;
        m_status_reg   <= m_status_next;
        m_key_reg      <= m_key_next;
        m_val_reg      <= m_val_next;
        m_pos_reg      <= m_pos_next;
        m_count_reg    <= m_count_next;
        m_last_reg     <= m_last_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({m_count_reg, m_pos_reg, m_val_reg, m_key_reg});

endmodule

`default_nettype wire

/* hw/rtl/krt_checker.sv */
// Port-level checks for keyed_record_table_unit, attached by bind.
// Depends on krt_pkg.
`default_nettype none

module krt_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [krt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic [krt_pkg::STAT_W-1:0]     m_axis_tuser,
    input wire logic                           m_axis_tlast
);
    import krt_pkg::*;

    logic [COUNT_W-1:0] count_w;
    assign count_w = m_axis_tdata[COUNT_LSB +: COUNT_W];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tlast)
        else $error("error status without last");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_FULL) |-> (count_w == COUNT_W'(DEPTH)))
        else $error("full status with wrong count");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |-> (count_w == '0))
        else $error("empty status with nonzero count");

endmodule

bind keyed_record_table_unit krt_checker u_krt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
